### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FWDF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("formatter assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FWDF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("formatter assertion failed");

`endif

### hdl/fwdf_pkg.sv
package fwdf_pkg;

    localparam int VALUE_W        = 32;
    localparam int FRAC_BITS      = 16;
    localparam int MAX_INT_FIELD  = 8;
    localparam int MAX_FRAC_FIELD = 4;

    localparam int INT_CFG_W  = 4;
    localparam int FRAC_CFG_W = 3;
    localparam int CHAR_W     = 6;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    function automatic int ndigits(longint v);
        int     n;
        longint t;
        n = 1;
        t = v;
        for (int i = 0; i < 24; i++) begin
            if (t >= 10) begin
                t = t / 10;
                n = n + 1;
            end
        end
        return n;
    endfunction

    localparam int     IP_W      = VALUE_W - FRAC_BITS;
    localparam int     INT_NDIG  = ndigits((longint'(1) << IP_W) - 1);
    localparam int     FRAC_NDIG = MAX_FRAC_FIELD;
    localparam longint MAX_P10   = 10 ** MAX_FRAC_FIELD;
    localparam int     DEC_W     = $clog2(MAX_P10);
    localparam int     DCMP_W    = DEC_W + 1;
    localparam int     PROD_W    = FRAC_BITS + DEC_W;
    localparam int     DAB_W     = (IP_W > DEC_W) ? IP_W : DEC_W;
    localparam int     DAB_CNT_W = $clog2(DAB_W + 1);
    localparam int     POS_W     = $clog2(MAX_INT_FIELD + 1 + MAX_FRAC_FIELD);
    localparam int     ND_W      = $clog2(INT_NDIG + 1);

    localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1) << (FRAC_BITS - 1);

    localparam logic [CHAR_W-1:0] CH_SPACE = CHAR_W'(32);
    localparam logic [CHAR_W-1:0] CH_MINUS = CHAR_W'(45);
    localparam logic [CHAR_W-1:0] CH_POINT = CHAR_W'(46);
    localparam logic [CHAR_W-1:0] CH_ZERO  = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] CH_NINE  = CHAR_W'(57);

    typedef enum logic {
        REG_INT_DIGITS  = 1'b0,
        REG_FRAC_DIGITS = 1'b1
    } t_reg_idx;

    function automatic logic [INT_CFG_W-1:0] clamp_int(logic [INT_CFG_W-1:0] v);
        logic [INT_CFG_W-1:0] r;
        r = v;
        if (v == '0) r = INT_CFG_W'(1);
        else if (v > INT_CFG_W'(MAX_INT_FIELD)) r = INT_CFG_W'(MAX_INT_FIELD);
        return r;
    endfunction

    function automatic logic [FRAC_CFG_W-1:0] clamp_frac(logic [FRAC_CFG_W-1:0] v);
        logic [FRAC_CFG_W-1:0] r;
        r = v;
        if (v == '0) r = FRAC_CFG_W'(1);
        else if (v > FRAC_CFG_W'(MAX_FRAC_FIELD)) r = FRAC_CFG_W'(MAX_FRAC_FIELD);
        return r;
    endfunction

endpackage

### hdl/fwdf_in_if.sv
interface fwdf_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [fwdf_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

### hdl/fwdf_out_if.sv
interface fwdf_out_if;
    logic                          valid;
    logic                          ready;
    logic [fwdf_pkg::CHAR_W-1:0]   character;
    logic                          last;
    logic                          overflow;

    modport source (output valid, output character, output last, output overflow, input ready);
    modport sink (input valid, input character, input last, input overflow, output ready);
endinterface

### hdl/fwdf_dabble.sv
module fwdf_dabble (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    input  logic [fwdf_pkg::IP_W-1:0]               i_int_bin,
    input  logic [fwdf_pkg::DEC_W-1:0]              i_frac_bin,
    output logic [4*fwdf_pkg::INT_NDIG-1:0]         o_int_bcd,
    output logic [4*fwdf_pkg::FRAC_NDIG-1:0]        o_frac_bcd,
    output logic                                    o_done
);

    logic                                   r_busy;
    logic                                   r_done;
    logic [fwdf_pkg::DAB_CNT_W-1:0]         r_cnt;
    logic [fwdf_pkg::DAB_W-1:0]             r_ibin;
    logic [fwdf_pkg::DAB_W-1:0]             r_fbin;
    logic [4*fwdf_pkg::INT_NDIG-1:0]        r_ibcd;
    logic [4*fwdf_pkg::FRAC_NDIG-1:0]       r_fbcd;
    logic [4*fwdf_pkg::INT_NDIG-1:0]        w_ifix;
    logic [4*fwdf_pkg::FRAC_NDIG-1:0]       w_ffix;

    // Each digit of 5 or more gets 3 added before the next shift.
    always_comb begin
        for (int i = 0; i < fwdf_pkg::INT_NDIG; i++) begin
            w_ifix[4*i +: 4] = (r_ibcd[4*i +: 4] >= 4'd5) ? r_ibcd[4*i +: 4] + 4'd3
                                                          : r_ibcd[4*i +: 4];
        end
        for (int i = 0; i < fwdf_pkg::FRAC_NDIG; i++) begin
            w_ffix[4*i +: 4] = (r_fbcd[4*i +: 4] >= 4'd5) ? r_fbcd[4*i +: 4] + 4'd3
                                                          : r_fbcd[4*i +: 4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= fwdf_pkg::DAB_CNT_W'(fwdf_pkg::DAB_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == fwdf_pkg::DAB_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ibin <= fwdf_pkg::DAB_W'(i_int_bin);
            r_fbin <= fwdf_pkg::DAB_W'(i_frac_bin);
            r_ibcd <= '0;
            r_fbcd <= '0;
        end else if (r_busy) begin
            r_ibin <= r_ibin << 1;
            r_fbin <= r_fbin << 1;
            r_ibcd <= {w_ifix[4*fwdf_pkg::INT_NDIG-2:0], r_ibin[fwdf_pkg::DAB_W-1]};
            r_fbcd <= {w_ffix[4*fwdf_pkg::FRAC_NDIG-2:0], r_fbin[fwdf_pkg::DAB_W-1]};
        end
    end

    assign o_int_bcd  = r_ibcd;
    assign o_frac_bcd = r_fbcd;
    assign o_done     = r_done;

endmodule

### hdl/fixed_width_decimal_formatter_unit.sv
// Fixed-width decimal formatter.
// The input channel takes one signed fixed-point value (16 fraction bits) per beat.
// The output channel returns the field one ASCII character per beat: spaces or
// dropped leading characters, an optional minus, the integer digits, a point and
// the rounded fraction digits. The last beat of a field carries last, and every
// beat of a field whose leading characters were dropped carries overflow.
// The APB port holds int_digits at address 0 and frac_digits at address 4.
// Processing: after an input beat the fraction is scaled by 10 to the power frac_digits
// in S_MUL, rounded in S_ROUND, then converted to BCD by the shift-and-add-3 unit,
// which sets the bulk of the latency. Once the first character is valid, the rest
// follow one per cycle while the receiver is ready.
// Input ready is high only while no field is being built or emitted; the last beat
// of the previous field may still be waiting in the output register.
// When the receiver stalls, the current character holds in the output register
// and the block waits. Reset empties the output, drops any item in progress and
// sets both registers to 2.
module fixed_width_decimal_formatter_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    fwdf_in_if.sink                        i_in,
    fwdf_out_if.source                     o_out,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [fwdf_pkg::ADDR_W-1:0]    i_paddr,
    input  logic [fwdf_pkg::DATA_W-1:0]    i_pwdata,
    output logic [fwdf_pkg::DATA_W-1:0]    o_prdata,
    output logic                           o_pready
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_MUL    = 5'b00010,
        S_ROUND  = 5'b00100,
        S_DABBLE = 5'b01000,
        S_EMIT   = 5'b10000
    } t_state;

    t_state                                 r_state;
    logic [fwdf_pkg::INT_CFG_W-1:0]         r_cfg_int;
    logic [fwdf_pkg::FRAC_CFG_W-1:0]        r_cfg_frac;
    logic [fwdf_pkg::INT_CFG_W-1:0]         r_n_int;
    logic [fwdf_pkg::FRAC_CFG_W-1:0]        r_n_frac;
    logic [fwdf_pkg::FRAC_CFG_W-1:0]        r_mcnt;
    logic [fwdf_pkg::POS_W-1:0]             r_pos;
    logic                                   r_neg;
    logic [fwdf_pkg::IP_W-1:0]              r_ipart;
    logic [fwdf_pkg::PROD_W-1:0]            r_prod;
    logic [fwdf_pkg::DCMP_W-1:0]            r_p10;
    logic                                   r_ovalid;
    logic [fwdf_pkg::CHAR_W-1:0]            r_char;
    logic                                   r_last;
    logic                                   r_ovf;

    logic [fwdf_pkg::VALUE_W-1:0]           w_mag;
    logic [fwdf_pkg::PROD_W:0]              w_sum;
    logic [fwdf_pkg::DCMP_W-1:0]            w_dec;
    logic                                   w_carry;
    logic [fwdf_pkg::IP_W-1:0]              w_int_bin;
    logic [fwdf_pkg::DEC_W-1:0]             w_frac_bin;
    logic                                   w_dab_start;
    logic                                   w_dab_done;
    logic [4*fwdf_pkg::INT_NDIG-1:0]        w_int_bcd;
    logic [4*fwdf_pkg::FRAC_NDIG-1:0]       w_frac_bcd;
    logic [fwdf_pkg::ND_W-1:0]              w_nd;
    logic [fwdf_pkg::CHAR_W-1:0]            w_char;
    logic                                   w_last;
    logic                                   w_ovf;
    logic                                   w_in_acc;
    logic                                   w_load;
    logic                                   w_cfg_wr;

    assign w_in_acc = i_in.valid && i_in.ready;
    assign w_mag    = i_in.value[fwdf_pkg::VALUE_W-1]
                    ? (~$unsigned(i_in.value) + 1'b1) : $unsigned(i_in.value);

    assign w_sum      = {1'b0, r_prod} + fwdf_pkg::ROUND_HALF;
    assign w_dec      = w_sum[fwdf_pkg::PROD_W:fwdf_pkg::FRAC_BITS];
    assign w_carry    = (w_dec >= r_p10);
    assign w_int_bin  = r_ipart + fwdf_pkg::IP_W'(w_carry);
    assign w_frac_bin = w_carry ? '0 : w_dec[fwdf_pkg::DEC_W-1:0];
    assign w_dab_start = (r_state == S_ROUND);

    fwdf_dabble u_dabble (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_dab_start),
        .i_int_bin  (w_int_bin),
        .i_frac_bin (w_frac_bin),
        .o_int_bcd  (w_int_bcd),
        .o_frac_bcd (w_frac_bcd),
        .o_done     (w_dab_done)
    );

    always_comb begin
        w_nd = fwdf_pkg::ND_W'(1);
        for (int i = 0; i < fwdf_pkg::INT_NDIG; i++) begin
            if (w_int_bcd[4*i +: 4] != 4'd0) w_nd = fwdf_pkg::ND_W'(i + 1);
        end
    end

    assign w_ovf  = (int'(w_nd) + int'(r_neg)) > int'(r_n_int);
    assign w_last = int'(r_pos) == (int'(r_n_int) + int'(r_n_frac));

    always_comb begin
        int rpos;
        int fpos;
        rpos   = int'(r_n_int) - 1 - int'(r_pos);
        fpos   = int'(r_n_int) + int'(r_n_frac) - int'(r_pos);
        w_char = fwdf_pkg::CH_SPACE;
        if (int'(r_pos) < int'(r_n_int)) begin
            if (rpos < int'(w_nd)) begin
                for (int i = 0; i < fwdf_pkg::INT_NDIG; i++) begin
                    if (rpos == i) begin
                        w_char = fwdf_pkg::CH_ZERO + fwdf_pkg::CHAR_W'(w_int_bcd[4*i +: 4]);
                    end
                end
            end else if (rpos == int'(w_nd) && r_neg) begin
                w_char = fwdf_pkg::CH_MINUS;
            end
        end else if (int'(r_pos) == int'(r_n_int)) begin
            w_char = fwdf_pkg::CH_POINT;
        end else begin
            for (int i = 0; i < fwdf_pkg::FRAC_NDIG; i++) begin
                if (fpos == i) begin
                    w_char = fwdf_pkg::CH_ZERO + fwdf_pkg::CHAR_W'(w_frac_bcd[4*i +: 4]);
                end
            end
        end
    end

    assign w_load   = (r_state == S_EMIT) && (!r_ovalid || o_out.ready);
    assign w_cfg_wr = i_psel && i_penable && i_pwrite && o_pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cfg_int  <= fwdf_pkg::INT_CFG_W'(2);
            r_cfg_frac <= fwdf_pkg::FRAC_CFG_W'(2);
            r_ovalid   <= 1'b0;
            r_mcnt     <= '0;
            r_pos      <= '0;
        end else begin
            if (w_cfg_wr) begin
                case (fwdf_pkg::t_reg_idx'(i_paddr[fwdf_pkg::ADDR_W-1]))
                    fwdf_pkg::REG_INT_DIGITS:
                        r_cfg_int <= i_pwdata[fwdf_pkg::INT_CFG_W-1:0];
                    fwdf_pkg::REG_FRAC_DIGITS:
                        r_cfg_frac <= i_pwdata[fwdf_pkg::FRAC_CFG_W-1:0];
                    default: ;
                endcase
            end

            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_mcnt  <= fwdf_pkg::clamp_frac(r_cfg_frac);
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_mcnt <= r_mcnt - 1'b1;
                    if (r_mcnt == fwdf_pkg::FRAC_CFG_W'(1)) r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_state <= S_DABBLE;
                end
                S_DABBLE: begin
                    r_pos <= '0;
                    if (w_dab_done) r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_load) begin
                        r_pos <= r_pos + 1'b1;
                        if (w_last) r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_n_int  <= fwdf_pkg::clamp_int(r_cfg_int);
            r_n_frac <= fwdf_pkg::clamp_frac(r_cfg_frac);
            r_neg    <= i_in.value[fwdf_pkg::VALUE_W-1];
            r_ipart  <= w_mag[fwdf_pkg::VALUE_W-1:fwdf_pkg::FRAC_BITS];
            r_prod   <= fwdf_pkg::PROD_W'(w_mag[fwdf_pkg::FRAC_BITS-1:0]);
            r_p10    <= fwdf_pkg::DCMP_W'(1);
        end else if (r_state == S_MUL) begin
            r_prod <= (r_prod << 3) + (r_prod << 1);
            r_p10  <= (r_p10 << 3) + (r_p10 << 1);
        end
        if (w_load) begin
            r_char <= w_char;
            r_last <= w_last;
            r_ovf  <= w_ovf;
        end
    end

    always_comb begin
        case (fwdf_pkg::t_reg_idx'(i_paddr[fwdf_pkg::ADDR_W-1]))
            fwdf_pkg::REG_INT_DIGITS:  o_prdata = fwdf_pkg::DATA_W'(r_cfg_int);
            fwdf_pkg::REG_FRAC_DIGITS: o_prdata = fwdf_pkg::DATA_W'(r_cfg_frac);
            default:                   o_prdata = '0;
        endcase
    end

    assign o_pready        = 1'b1;
    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_ovalid;
    assign o_out.character = r_char;
    assign o_out.last      = r_last;
    assign o_out.overflow  = r_ovf;

endmodule

### hdl/fwdf_checker.sv
`include "assert_macros.svh"

module fwdf_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [fwdf_pkg::CHAR_W-1:0]   i_out_char,
    input logic                          i_out_last,
    input logic                          i_out_ovf
);

    // A new value is not taken while the previous field is being built.
    `FWDF_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // A stalled beat keeps its character and flags.
    `FWDF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_char) && $stable(i_out_last) && $stable(i_out_ovf))

    // Only space, minus, point and digits are ever sent.
    `FWDF_ASSERT_NOW(a_char_legal, i_clk, i_rst_n, i_out_valid, i_out_char == fwdf_pkg::CH_SPACE || i_out_char == fwdf_pkg::CH_MINUS || i_out_char == fwdf_pkg::CH_POINT || (i_out_char >= fwdf_pkg::CH_ZERO && i_out_char <= fwdf_pkg::CH_NINE))

    // The next field cannot follow the last beat directly.
    `FWDF_ASSERT_NEXT(a_gap_after_last, i_clk, i_rst_n, i_out_valid && i_out_ready && i_out_last, !i_out_valid)

endmodule

bind fixed_width_decimal_formatter_unit fwdf_checker u_fwdf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.character),
    .i_out_last  (o_out.last),
    .i_out_ovf   (o_out.overflow)
);

### tb/sv/fixed_width_decimal_formatter_unit_tb.sv
module fixed_width_decimal_formatter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fwdf_pkg::*;

    localparam int          CLK_PERIOD      = 8;
    localparam int          RESET_CYCLES    = 7;
    localparam int          IDLE_PERCENT    = 13;
    localparam int          RANDOM_PHASES   = 8;
    localparam int          ITEMS_PER_PHASE = 40;
    localparam int          STEADY_PHASE    = 5;
    localparam int          DRAIN_CYCLES    = 60;
    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int          MAX_FIELD       = MAX_INT_FIELD + 1 + MAX_FRAC_FIELD;
    localparam int          MAX_PRINTED     = 40;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
        logic              overflow;
    } field_char_t;

    typedef enum {
        ROW_WRITE,
        ROW_VALUE
    } row_kind_t;

    typedef struct {
        row_kind_t         kind;
        t_reg_idx          reg_idx;
        logic [DATA_W-1:0] data;
        string             text;
        bit                overflow;
    } directed_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    fwdf_in_if  in_ch ();
    fwdf_out_if out_ch ();

    fixed_width_decimal_formatter_unit dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_in      (in_ch),
        .o_out     (out_ch),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready)
    );

    field_char_t           pending_chars[$];
    logic [INT_CFG_W-1:0]  int_width_reg  = INT_CFG_W'(2);
    logic [FRAC_CFG_W-1:0] frac_width_reg = FRAC_CFG_W'(2);
    int unsigned           mismatch_count = 0;
    int unsigned           cycle_count    = 0;
    bit                    steady_flow    = 1'b0;

    directed_row_t directed_rows[27] = '{
        '{ROW_VALUE, REG_INT_DIGITS,  32'h0000_0000, " 0.00",         1'b0},
        '{ROW_VALUE, REG_INT_DIGITS,  32'h0001_0000, " 1.00",         1'b0},
        '{ROW_VALUE, REG_INT_DIGITS,  32'hFFFF_0000, "-1.00",         1'b0},
        '{ROW_VALUE, REG_INT_DIGITS,  32'h7FFF_FFFF, "68.00",         1'b1},
        '{ROW_VALUE, REG_INT_DIGITS,  32'h8000_0000, "68.00",         1'b1},
        '{ROW_VALUE, REG_INT_DIGITS,  32'hFFFF_FFFF, "-0.00",         1'b0},
        '{ROW_VALUE, REG_INT_DIGITS,  32'h0000_8000, "",              1'b0},
        '{ROW_VALUE, REG_INT_DIGITS,  32'h0000_FFFF, "",              1'b0},
        '{ROW_WRITE, REG_INT_DIGITS,  32'd8,         "",              1'b0},
        '{ROW_WRITE, REG_FRAC_DIGITS, 32'd4,         "",              1'b0},
        '{ROW_VALUE, REG_INT_DIGITS,  32'h7FFF_FFFF, "   32768.0000", 1'b0},
        '{ROW_VALUE, REG_INT_DIGITS,  32'h8000_0000, "  -32768.0000", 1'b0},
        '{ROW_VALUE, REG_INT_DIGITS,  32'hFFFF_FFFF, "      -0.0000", 1'b0},
        '{ROW_VALUE, REG_INT_DIGITS,  32'h0000_FFFF, "",              1'b0},
        '{ROW_WRITE, REG_INT_DIGITS,  32'd1,         "",              1'b0},
        '{ROW_WRITE, REG_FRAC_DIGITS, 32'd1,         "",              1'b0},
        '{ROW_VALUE, REG_INT_DIGITS,  32'h0000_0000, "0.0",           1'b0},
        '{ROW_VALUE, REG_INT_DIGITS,  32'hFFFF_0000, "1.0",           1'b1},
        '{ROW_VALUE, REG_INT_DIGITS,  32'h000A_8000, "",              1'b0},
        '{ROW_WRITE, REG_INT_DIGITS,  32'd0,         "",              1'b0},
        '{ROW_WRITE, REG_FRAC_DIGITS, 32'd0,         "",              1'b0},
        '{ROW_VALUE, REG_INT_DIGITS,  32'h0003_0000, "3.0",           1'b0},
        '{ROW_VALUE, REG_INT_DIGITS,  32'h0005_1999, "",              1'b0},
        '{ROW_WRITE, REG_INT_DIGITS,  32'd15,        "",              1'b0},
        '{ROW_WRITE, REG_FRAC_DIGITS, 32'd7,         "",              1'b0},
        '{ROW_VALUE, REG_INT_DIGITS,  32'h0001_0000, "       1.0000", 1'b0},
        '{ROW_VALUE, REG_INT_DIGITS,  32'hFFFE_8000, "",              1'b0}
    };

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk) cycle_count <= cycle_count + 1;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) begin
            $display("%0t ns: mismatch: %s", $time, what);
        end
    endtask

    function automatic void predict_field(input logic signed [VALUE_W-1:0] value);
        logic [CHAR_W-1:0] head[MAX_FIELD];
        logic [CHAR_W-1:0] field[MAX_FIELD];
        longint            signed_value;
        longint unsigned   mag;
        longint unsigned   int_part;
        longint unsigned   frac_part;
        longint unsigned   scale;
        longint unsigned   frac_dec;
        longint unsigned   rest;
        int                n_int;
        int                n_frac;
        int                total;
        int                head_len;
        int                first;
        int                pad;
        int                pos;
        int                ndig;
        bit                neg;
        bit                ovf;
        field_char_t       beat;

        n_int = (int_width_reg == 0) ? 1 :
                (int_width_reg > MAX_INT_FIELD) ? MAX_INT_FIELD : int'(int_width_reg);
        n_frac = (frac_width_reg == 0) ? 1 :
                 (frac_width_reg > MAX_FRAC_FIELD) ? MAX_FRAC_FIELD : int'(frac_width_reg);
        total = n_int + 1 + n_frac;

        signed_value = value;
        neg = signed_value < 0;
        mag = neg ? -signed_value : signed_value;
        int_part = mag >> FRAC_BITS;
        frac_part = mag & ((64'd1 << FRAC_BITS) - 1);
        scale = 1;
        for (int i = 0; i < n_frac; i++) scale = scale * 10;
        frac_dec = (frac_part * scale + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (frac_dec >= scale) begin
            frac_dec = 0;
            int_part = int_part + 1;
        end

        head_len = 0;
        if (neg) begin
            head[0] = CH_MINUS;
            head_len = 1;
        end
        ndig = 0;
        rest = int_part;
        do begin
            ndig++;
            rest = rest / 10;
        end while (rest != 0);
        for (int i = ndig - 1; i >= 0; i--) begin
            head[head_len + i] = CH_ZERO + CHAR_W'(int_part % 10);
            int_part = int_part / 10;
        end
        head_len = head_len + ndig;

        ovf = head_len > n_int;
        first = ovf ? head_len - n_int : 0;
        pad = ovf ? 0 : n_int - head_len;
        pos = 0;
        for (int i = 0; i < pad; i++) begin
            field[pos] = CH_SPACE;
            pos++;
        end
        for (int i = first; i < head_len; i++) begin
            field[pos] = head[i];
            pos++;
        end
        field[pos] = CH_POINT;
        pos++;
        for (int i = n_frac - 1; i >= 0; i--) begin
            field[pos + i] = CH_ZERO + CHAR_W'(frac_dec % 10);
            frac_dec = frac_dec / 10;
        end

        for (int i = 0; i < total; i++) begin
            beat.character = field[i];
            beat.last = (i == total - 1);
            beat.overflow = ovf;
            pending_chars.push_back(beat);
        end
    endfunction

    function automatic void queue_text(input string text, input bit ovf);
        field_char_t beat;
        for (int i = 0; i < text.len(); i++) begin
            beat.character = CHAR_W'(text[i]);
            beat.last = (i == text.len() - 1);
            beat.overflow = ovf;
            pending_chars.push_back(beat);
        end
    endfunction

    function automatic logic signed [VALUE_W-1:0] random_value();
        logic [IP_W-1:0]            whole;
        logic [FRAC_BITS-1:0]       part;
        logic signed [VALUE_W-1:0]  v;
        longint unsigned            decade;

        decade = 1;
        for (int i = $urandom_range(0, 4); i > 0; i--) decade = decade * 10;
        part = FRAC_BITS'($urandom);
        whole = '0;
        case ($urandom_range(0, 4))
            0: begin
                return VALUE_W'($urandom);
            end
            1: begin
                whole = IP_W'($urandom_range(0, 99));
            end
            2: begin
                whole = IP_W'($urandom_range(0, 999));
                part = $urandom_range(0, 1) ? ~FRAC_BITS'($urandom_range(0, 60))
                                            : FRAC_BITS'($urandom_range(0, 60));
            end
            3: begin
                whole = IP_W'(decade - $urandom_range(0, 1));
                if ($urandom_range(0, 1)) part = ~FRAC_BITS'($urandom_range(0, 200));
            end
            default: begin
                return {($urandom_range(0, 1) ? IP_W'(16'h8000) : IP_W'(16'h7FFF)), part};
            end
        endcase
        v = {whole, part};
        if ($urandom_range(0, 1)) v = -v;
        return v;
    endfunction

    // An empty text means the expected field comes from the predictor.
    task automatic send_value(input logic signed [VALUE_W-1:0] value, input string text,
                              input bit ovf);
        while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) @(negedge clk);
        in_ch.valid = 1'b1;
        in_ch.value = value;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        if (text.len() == 0) predict_field(value);
        else queue_text(text, ovf);
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_chars.size() != 0) @(negedge clk);
    endtask

    task automatic write_register(input t_reg_idx idx, input logic [DATA_W-1:0] data);
        logic [DATA_W-1:0] stored;
        stored = (idx == REG_INT_DIGITS) ? DATA_W'(data[INT_CFG_W-1:0])
                                         : DATA_W'(data[FRAC_CFG_W-1:0]);
        paddr = ADDR_W'(4 * int'(idx));
        pwdata = data;
        pwrite = 1'b1;
        psel = 1'b1;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (idx == REG_INT_DIGITS) int_width_reg = data[INT_CFG_W-1:0];
        else frac_width_reg = data[FRAC_CFG_W-1:0];
        @(negedge clk);
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (prdata !== stored) begin
            report_mismatch($sformatf("register %s reads %0h, expected %0h",
                                      idx.name(), prdata, stored));
        end
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            out_ch.ready = steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Every output beat is matched against the oldest expected character.
    always @(posedge clk) begin
        field_char_t want;
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (pending_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected beat, character %0d",
                                          out_ch.character));
            end else begin
                want = pending_chars.pop_front();
                if (out_ch.character !== want.character) begin
                    report_mismatch($sformatf("character %0d, expected %0d",
                                              out_ch.character, want.character));
                end
                if (out_ch.last !== want.last) begin
                    report_mismatch($sformatf("last %b, expected %b",
                                              out_ch.last, want.last));
                end
                if (out_ch.overflow !== want.overflow) begin
                    report_mismatch($sformatf("overflow %b, expected %b",
                                              out_ch.overflow, want.overflow));
                end
            end
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int unsigned int_sel;
        int unsigned frac_sel;

        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.value = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_WRITE) begin
                wait_drained();
                write_register(directed_rows[i].reg_idx, directed_rows[i].data);
            end else begin
                send_value(directed_rows[i].data, directed_rows[i].text,
                           directed_rows[i].overflow);
            end
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_drained();
            steady_flow = (phase == STEADY_PHASE);
            case (phase)
                0: begin
                    int_sel = 1;
                    frac_sel = MAX_FRAC_FIELD;
                end
                1: begin
                    int_sel = MAX_INT_FIELD;
                    frac_sel = 1;
                end
                2: begin
                    int_sel = 0;
                    frac_sel = 7;
                end
                3: begin
                    int_sel = 15;
                    frac_sel = 0;
                end
                default: begin
                    int_sel = $urandom_range(0, 15);
                    frac_sel = $urandom_range(0, 7);
                end
            endcase
            write_register(REG_INT_DIGITS, ($urandom & ~DATA_W'(15)) | DATA_W'(int_sel));
            write_register(REG_FRAC_DIGITS, ($urandom & ~DATA_W'(7)) | DATA_W'(frac_sel));
            repeat (ITEMS_PER_PHASE) send_value(random_value(), "", 1'b0);
        end
        steady_flow = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_chars.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
